>>> sv/simple_risc_core_execute_top_defines.svh
// ----------------------------------------------------------------------------
// simple_risc_core_execute_top_defines
// Assertion helper macros for the small RISC core.
// ----------------------------------------------------------------------------
`ifndef SIMPLE_RISC_CORE_EXECUTE_TOP_DEFINES_SVH
`define SIMPLE_RISC_CORE_EXECUTE_TOP_DEFINES_SVH
// concurrent implication checked on every rising clock edge outside reset
`define SRC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define SRC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

>>> sv/src_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// src_pkg
// Shared types and codes for the small RISC core.
// ----------------------------------------------------------------------------
package src_pkg;
    typedef enum logic [1:0] {
        CMD_WRITE_MEM = 2'd0,
        CMD_EXECUTE   = 2'd1,
        CMD_READ_MEM  = 2'd2,
        CMD_READ_REG  = 2'd3
    } t_cmd;

    localparam logic [3:0] OP_ADD  = 4'd0;
    localparam logic [3:0] OP_SUB  = 4'd1;
    localparam logic [3:0] OP_AND  = 4'd2;
    localparam logic [3:0] OP_OR   = 4'd3;
    localparam logic [3:0] OP_SLL  = 4'd4;
    localparam logic [3:0] OP_SRA  = 4'd5;
    localparam logic [3:0] OP_BEQ  = 4'd7;
    localparam logic [3:0] OP_BGT  = 4'd8;
    localparam logic [3:0] OP_BLE  = 4'd9;
    localparam logic [3:0] OP_BNE  = 4'd10;
    localparam logic [3:0] OP_JAL  = 4'd11;
    localparam logic [3:0] OP_LW   = 4'd12;
    localparam logic [3:0] OP_SW   = 4'd13;
    localparam logic [3:0] OP_LHI  = 4'd14;
    localparam logic [3:0] OP_HALT = 4'd15;

    localparam logic [3:0]  REG_IMM  = 4'd1;
    localparam logic [3:0]  REG_LINK = 4'd15;
    localparam logic [15:0] HALT_WORD = 16'h000F;

    typedef struct packed {
        logic [31:0] read_data;
        logic [15:0] pc;
        logic        halted;
        logic [31:0] count;
        logic [15:0] highest;
    } t_result;
endpackage
`default_nettype wire

>>> sv/simple_risc_core_execute_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// simple_risc_core_execute_top
// Sixteen-register RISC core with a word memory, driven by commands.
// ----------------------------------------------------------------------------
// channel  dir  tdata fields (low bit first)
// s_axis   in   command[1:0], address[17:2], write_data[33:18]
// m_axis   out  read_data, program_counter_out, halted, executed_count,
//                highest_used
// States from an input beat to ready, each path ending in done and idle:
// register read fetch; memory write or read fetch, load; execute fetch,
// decode, immediate slot, execute, plus load for a load; halted execute
// fetch. The immediate slot runs even without an immediate. One command in
// flight; a result held by m_axis_tready holds the command in DONE and stalls
// the input. Reset clears registers and counters; memory is left.
// ----------------------------------------------------------------------------
`include "simple_risc_core_execute_top_defines.svh"
module simple_risc_core_execute_top #(
    parameter int ADDR_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // command[1:0], address[17:2], write_data[33:18], zero pad
    input  wire logic [39:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // read_data[31:0], pc[47:32], halted[48], executed_count[80:49],
    // highest_used[96:81], zero pad
    output logic [103:0]     m_axis_tdata
);
    import src_pkg::*;
    localparam int AW = ADDR_BITS;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_FETCH = 7'b0000010,
        S_DEC   = 7'b0000100,
        S_IMM   = 7'b0001000,
        S_EXEC  = 7'b0010000,
        S_LOAD  = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state       r_state, n_state;
    t_cmd         r_cmd;
    logic [15:0]  r_addr, r_wdata;
    logic [31:0]  r_regs [16];
    logic [AW-1:0] r_pc;
    logic         r_halt;
    logic [31:0]  r_count;
    logic [AW-1:0] r_high;
    logic [15:0]  r_word;
    logic [31:0]  r_imm;
    logic         r_ovalid;
    t_result      r_res;

    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [15:0]   mem_wdata, mem_rdata;

    src_ram #(.WIDTH(16), .DEPTH(1 << AW)) u_ram (
        .i_clk(i_clk), .i_we(mem_we), .i_addr(mem_addr),
        .i_wdata(mem_wdata), .o_rdata(mem_rdata)
    );

    logic        in_acc, out_free;
    logic [3:0]  f_op, f_rd, f_rs, f_rt;
    logic        need_imm;
    logic [31:0] ra, rb, rd_v, alu_res;
    logic        take;
    logic [AW-1:0] ls_addr, pc_at, tgt;
    logic [AW-1:0] pc_seq, n_pc;
    logic          br_go;

    assign out_free      = !r_ovalid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign f_op = (r_word == HALT_WORD) ? OP_HALT : r_word[15:12];
    assign f_rd = r_word[11:8];
    assign f_rs = r_word[7:4];
    assign f_rt = r_word[3:0];
    assign need_imm = (f_rd == REG_IMM) || (f_rs == REG_IMM) || (f_rt == REG_IMM);

    function automatic logic [31:0] rsel(input logic [3:0] i, input logic [31:0] imm,
                                         input logic [31:0] v);
        logic [31:0] x;
        x = (i == REG_IMM) ? imm : v;
        return x;
    endfunction

    assign ra   = rsel(f_rs, r_imm, r_regs[f_rs]);
    assign rb   = rsel(f_rt, r_imm, r_regs[f_rt]);
    assign rd_v = rsel(f_rd, r_imm, r_regs[f_rd]);
    assign ls_addr = AW'(ra + rb);
    assign pc_at = r_pc + AW'(need_imm);
    assign tgt   = AW'(rd_v[15:0]);
    assign pc_seq = pc_at + AW'(1);
    assign br_go  = take && (r_high >= tgt) && (rd_v[15:0] <= 16'(r_high));
    assign n_pc   = (f_op == OP_JAL) ? ((f_rd == REG_LINK) ? pc_seq : tgt)
                                     : (br_go ? tgt : pc_seq);

    src_alu u_alu (.i_op(f_op), .i_a(ra), .i_b(rb), .i_d(rd_v),
                   .o_result(alu_res), .o_take(take));

    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = r_addr[AW-1:0];
        mem_wdata = r_wdata;
        case (r_state)
            S_FETCH: begin
                if (r_cmd == CMD_EXECUTE) begin
                    mem_addr = r_pc;
                end else if (r_cmd == CMD_WRITE_MEM) begin
                    mem_we = 1'b1;
                end
            end
            S_DEC: mem_addr = r_pc + AW'(1);
            S_EXEC: begin
                mem_addr  = ls_addr;
                mem_we    = (f_op == OP_SW);
                mem_wdata = rd_v[15:0];
            end
            default: mem_addr = r_addr[AW-1:0];
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (in_acc) n_state = S_FETCH;
            S_FETCH: begin
                if (r_cmd == CMD_EXECUTE && !r_halt) n_state = S_DEC;
                else if (r_cmd == CMD_EXECUTE || r_cmd == CMD_READ_REG) n_state = S_DONE;
                else n_state = S_LOAD;
            end
            S_DEC:   n_state = S_IMM;
            S_IMM:   n_state = S_EXEC;
            S_EXEC:  n_state = (f_op == OP_LW) ? S_LOAD : S_DONE;
            S_LOAD:  n_state = S_DONE;
            S_DONE:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pc     <= '0;
            r_halt   <= 1'b0;
            r_count  <= '0;
            r_high   <= '0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < 16; i++) r_regs[i] <= '0;
        end else begin
            r_state <= n_state;
            r_ovalid <= (r_state == S_DONE && out_free) || (r_ovalid && !m_axis_tready);
            case (r_state)
                S_IDLE: if (in_acc) begin
                    r_cmd   <= t_cmd'(s_axis_tdata[1:0]);
                    r_addr  <= s_axis_tdata[17:2];
                    r_wdata <= s_axis_tdata[33:18];
                end
                S_FETCH: if (r_cmd == CMD_WRITE_MEM && r_addr[AW-1:0] > r_high) begin
                    r_high <= r_addr[AW-1:0];
                end
                S_DEC: r_word <= mem_rdata;
                S_IMM: begin
                    r_imm <= need_imm ? {{16{mem_rdata[15]}}, mem_rdata} : 32'd0;
                    r_regs[REG_IMM] <= need_imm ? {{16{mem_rdata[15]}}, mem_rdata} : 32'd0;
                end
                S_EXEC: begin
                    r_pc <= n_pc;
                    if (r_count != '1) r_count <= r_count + 32'd1;
                    case (f_op)
                        OP_ADD, OP_SUB, OP_AND, OP_OR, OP_SLL, OP_SRA, OP_LHI:
                            if (f_rd != 4'd0) r_regs[f_rd] <= alu_res;
                        OP_JAL: r_regs[REG_LINK] <= 32'(pc_seq);
                        OP_SW: if (ls_addr > r_high) r_high <= ls_addr;
                        OP_HALT: r_halt <= 1'b1;
                        default: r_halt <= r_halt;
                    endcase
                end
                S_LOAD: if (r_cmd == CMD_EXECUTE) begin
                    if (f_rd != 4'd0) r_regs[f_rd] <= {{16{mem_rdata[15]}}, mem_rdata};
                end
                S_DONE: if (out_free) begin
                    r_res.pc      <= 16'(r_pc);
                    r_res.halted  <= r_halt;
                    r_res.count   <= r_count;
                    r_res.highest <= 16'(r_high);
                    case (r_cmd)
                        CMD_READ_REG: r_res.read_data <= r_regs[r_addr[3:0]];
                        CMD_READ_MEM: r_res.read_data <= {16'd0, r_wdata};
                        default:      r_res.read_data <= 32'd0;
                    endcase
                end
                default: ;
            endcase
            if (r_state == S_LOAD && r_cmd == CMD_READ_MEM) r_wdata <= mem_rdata;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {7'd0, r_res.highest, r_res.count, r_res.halted,
                            r_res.pc, r_res.read_data};

    `SRC_ASSERT_IMP(a_one_hot, i_clk, i_rst_n, 1'b1, $onehot(r_state))
    `SRC_ASSERT_IMP(a_r0_zero, i_clk, i_rst_n, 1'b1, r_regs[0] == 32'd0)
    `SRC_ASSERT_NXT(a_halt_sticky, i_clk, i_rst_n, r_halt, r_halt)
    `SRC_ASSERT_NXT(a_high_mono, i_clk, i_rst_n, 1'b1, r_high >= $past(r_high))
endmodule
`default_nettype wire

>>> sv/src_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// src_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module src_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

>>> sv/src_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// src_alu
// Arithmetic, shift and branch compare for one instruction.
// ----------------------------------------------------------------------------
module src_alu (
    input  wire logic [3:0]  i_op,
    input  wire logic [31:0] i_a,
    input  wire logic [31:0] i_b,
    input  wire logic [31:0] i_d,
    output logic      [31:0] o_result,
    output logic             o_take
);
    import src_pkg::*;

    always_comb begin
        o_result = 32'd0;
        o_take   = 1'b0;
        case (i_op)
            OP_ADD:  o_result = i_a + i_b;
            OP_SUB:  o_result = i_a - i_b;
            OP_AND:  o_result = i_a & i_b;
            OP_OR:   o_result = i_a | i_b;
            OP_SLL:  o_result = i_a << i_b[4:0];
            OP_SRA:  o_result = $unsigned($signed(i_a) >>> i_b[4:0]);
            OP_LHI:  o_result = {i_a[15:0], i_d[15:0]};
            OP_BEQ:  o_take = (i_a == i_b);
            OP_BGT:  o_take = ($signed(i_a) > $signed(i_b));
            OP_BLE:  o_take = ($signed(i_a) <= $signed(i_b));
            OP_BNE:  o_take = (i_a != i_b);
            default: o_result = 32'd0;
        endcase
    end
endmodule
`default_nettype wire

>>> tb/simple_risc_core_execute_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// simple_risc_core_execute_top_tb
// Drives load, execute and read-back commands into the core and checks
// every result beat field by field against a cycle-free model of the core
// kept in this bench. Execute commands are only issued once every word the
// instruction will read has been loaded; the halt is saved for the end.
// ----------------------------------------------------------------------------
module simple_risc_core_execute_top_tb;
    import src_pkg::*;

    typedef struct packed {
        t_cmd        cmd;
        logic [15:0] addr;
        logic [15:0] data;
        logic        typed;
        logic [31:0] want;
    } t_row;

    localparam int N_ROWS = 24;
    localparam int N_RANDOM = 800;

    localparam t_row ROWS [N_ROWS] = '{
        '{CMD_READ_REG,  16'h0000, 16'h0000, 1'b1, 32'h0000_0000},
        '{CMD_WRITE_MEM, 16'h0000, 16'h0210, 1'b1, 32'h0000_0000},
        '{CMD_WRITE_MEM, 16'h0001, 16'h8000, 1'b0, 32'h0},
        '{CMD_WRITE_MEM, 16'h0002, 16'h5321, 1'b0, 32'h0},
        '{CMD_WRITE_MEM, 16'h0003, 16'h001F, 1'b0, 32'h0},
        '{CMD_WRITE_MEM, 16'h0004, 16'hA120, 1'b0, 32'h0},
        '{CMD_WRITE_MEM, 16'h0005, 16'h0100, 1'b0, 32'h0},
        '{CMD_WRITE_MEM, 16'h0006, 16'hBF00, 1'b0, 32'h0},
        '{CMD_WRITE_MEM, 16'h0007, 16'hC910, 1'b0, 32'h0},
        '{CMD_WRITE_MEM, 16'h0008, 16'h0001, 1'b0, 32'h0},
        '{CMD_WRITE_MEM, 16'h0009, 16'hD210, 1'b0, 32'h0},
        '{CMD_WRITE_MEM, 16'h000A, 16'hFFFF, 1'b0, 32'h0},
        '{CMD_WRITE_MEM, 16'h000B, 16'h6000, 1'b0, 32'h0},
        '{CMD_EXECUTE,   16'hFFFF, 16'hFFFF, 1'b0, 32'h0},
        '{CMD_EXECUTE,   16'h0000, 16'h0000, 1'b0, 32'h0},
        '{CMD_READ_REG,  16'h0003, 16'h0000, 1'b1, 32'hFFFF_FFFF},
        '{CMD_EXECUTE,   16'h0000, 16'h0000, 1'b0, 32'h0},
        '{CMD_EXECUTE,   16'h0000, 16'h0000, 1'b0, 32'h0},
        '{CMD_READ_REG,  16'hFFFF, 16'h0000, 1'b1, 32'h0000_0007},
        '{CMD_EXECUTE,   16'h0000, 16'h0000, 1'b0, 32'h0},
        '{CMD_READ_REG,  16'h0009, 16'h0000, 1'b1, 32'hFFFF_8000},
        '{CMD_EXECUTE,   16'h0000, 16'h0000, 1'b0, 32'h0},
        '{CMD_EXECUTE,   16'h0000, 16'h0000, 1'b0, 32'h0},
        '{CMD_READ_MEM,  16'hFFFF, 16'h0000, 1'b1, 32'h0000_8000}
    };

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // command[1:0], address[17:2], write_data[33:18], zero pad
    logic [39:0]  s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // read_data[31:0], pc[47:32], halted[48], executed_count[80:49],
    // highest_used[96:81], zero pad
    logic [103:0] m_axis_tdata;

    simple_risc_core_execute_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // core image
    bit [15:0] mem_img [65536];
    bit        loaded [65536];
    bit [15:0] loaded_addrs [$];
    bit [31:0] regs [16];
    bit [15:0] pc_q;
    bit        halt_q;
    bit [31:0] instr_count;
    bit [15:0] highest;
    bit        may_halt;

    t_result   pending_q [$];
    int        mismatches;
    int        results_seen;
    bit        calm;

    function automatic bit is_halt(bit [15:0] w);
        return w[15:12] == OP_HALT || w == HALT_WORD;
    endfunction

    function automatic bit [31:0] sext(bit [15:0] w);
        return {{16{w[15]}}, w};
    endfunction

    function automatic void store_word(bit [15:0] ad, bit [15:0] w);
        mem_img[ad] = w;
        if (!loaded[ad]) begin
            loaded[ad] = 1'b1;
            loaded_addrs.push_back(ad);
        end
        if (ad > highest) highest = ad;
    endfunction

    function automatic void set_reg(bit [3:0] r, bit [31:0] v);
        if (r != 4'd0) regs[r] = v;
    endfunction

    function automatic void run_instr();
        bit [15:0] pc;
        bit [15:0] word;
        bit [3:0]  op, rd, rs, rt;
        bit [31:0] a, b, d;
        bit [15:0] tgt;
        bit        take;
        pc = pc_q;
        word = mem_img[pc];
        {op, rd, rs, rt} = word;
        take = 1'b0;
        if (word == HALT_WORD) op = OP_HALT;
        regs[REG_IMM] = '0;
        if (rd == REG_IMM || rs == REG_IMM || rt == REG_IMM) begin
            pc = pc + 16'd1;
            regs[REG_IMM] = sext(mem_img[pc]);
        end
        a = regs[rs];
        b = regs[rt];
        d = regs[rd];
        tgt = d[15:0];
        case (op)
            OP_ADD:  set_reg(rd, a + b);
            OP_SUB:  set_reg(rd, a - b);
            OP_AND:  set_reg(rd, a & b);
            OP_OR:   set_reg(rd, a | b);
            OP_SLL:  set_reg(rd, a << b[4:0]);
            OP_SRA:  set_reg(rd, $signed(a) >>> b[4:0]);
            OP_BEQ:  take = a == b;
            OP_BGT:  take = $signed(a) > $signed(b);
            OP_BLE:  take = $signed(a) <= $signed(b);
            OP_BNE:  take = a != b;
            OP_JAL: begin
                regs[REG_LINK] = {16'd0, pc + 16'd1};
                pc = regs[rd][15:0] - 16'd1;
            end
            OP_LW:   set_reg(rd, sext(mem_img[a[15:0] + b[15:0]]));
            OP_SW:   store_word(a[15:0] + b[15:0], d[15:0]);
            OP_LHI:  set_reg(rd, {a[15:0], d[15:0]});
            OP_HALT: halt_q = 1'b1;
            default: ;
        endcase
        if (op >= OP_BEQ && op <= OP_BNE && take && highest >= tgt) pc = tgt - 16'd1;
        if (instr_count != 32'hFFFF_FFFF) instr_count++;
        pc_q = pc + 16'd1;
    endfunction

    function automatic t_result step_core(t_cmd c, bit [15:0] ad, bit [15:0] dt);
        t_result r;
        r = '0;
        case (c)
            CMD_WRITE_MEM: store_word(ad, dt);
            CMD_EXECUTE:   if (!halt_q) run_instr();
            CMD_READ_MEM:  r.read_data = {16'd0, mem_img[ad]};
            default:       r.read_data = regs[ad[3:0]];
        endcase
        r.pc = pc_q;
        r.halted = halt_q;
        r.count = instr_count;
        r.highest = highest;
        return r;
    endfunction

    // next word the instruction at pc would read that is not loaded yet, or pc if its word is the wrong halt kind
    function automatic int first_gap(output bit code_slot);
        bit [15:0] pc;
        bit [15:0] word;
        bit [31:0] imm, a, b;
        bit [15:0] ad;
        pc = pc_q;
        code_slot = 1'b1;
        if (halt_q) return -1;
        if (!loaded[pc] || is_halt(mem_img[pc]) != may_halt) return pc;
        code_slot = 1'b0;
        word = mem_img[pc];
        imm = '0;
        if (word[11:8] == REG_IMM || word[7:4] == REG_IMM || word[3:0] == REG_IMM) begin
            if (!loaded[pc + 16'd1]) return pc + 16'd1;
            imm = sext(mem_img[pc + 16'd1]);
        end
        if (word[15:12] == OP_LW && word != HALT_WORD) begin
            a = (word[7:4] == REG_IMM) ? imm : regs[word[7:4]];
            b = (word[3:0] == REG_IMM) ? imm : regs[word[3:0]];
            ad = a[15:0] + b[15:0];
            if (!loaded[ad]) return ad;
        end
        return -1;
    endfunction

    function automatic bit [3:0] pick_reg();
        return ($urandom_range(99) < 30) ? REG_IMM : 4'($urandom_range(15));
    endfunction

    function automatic bit [15:0] pick_code();
        bit [15:0] w;
        if (may_halt)
            return ($urandom_range(3) == 0) ? HALT_WORD : {OP_HALT, 12'($urandom)};
        w = {4'($urandom_range(14)), pick_reg(), pick_reg(), pick_reg()};
        if (w == HALT_WORD) w = '0;
        return w;
    endfunction

    function automatic bit [15:0] pick_word();
        return ($urandom_range(99) < 60) ? 16'($urandom_range(63)) : 16'($urandom);
    endfunction

    task automatic issue(t_cmd c, bit [15:0] ad, bit [15:0] dt, bit typed, bit [31:0] want);
        int gap;
        t_result r;
        gap = (calm || $urandom_range(99) >= 35) ? 0 : $urandom_range(1, 6);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'd0, dt, ad, c};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        r = step_core(c, ad, dt);
        if (typed) r.read_data = want;
        pending_q.push_back(r);
    endtask

    task automatic advance_program();
        bit code;
        int g;
        g = first_gap(code);
        if (g >= 0)
            issue(CMD_WRITE_MEM, g[15:0], code ? pick_code() : pick_word(), 1'b0, '0);
        else
            issue(CMD_EXECUTE, 16'($urandom), 16'($urandom), 1'b0, '0);
    endtask

    initial begin
        int k;
        int sent;
        bit [15:0] ad;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int i = 0; i < N_ROWS; i++)
            issue(ROWS[i].cmd, ROWS[i].addr, ROWS[i].data, ROWS[i].typed, ROWS[i].want);
        sent = 0;
        while (sent < N_RANDOM) begin
            calm = sent >= 250 && sent < 350;
            k = $urandom_range(99);
            if (k < 60) begin
                advance_program();
            end else if (k < 75) begin
                ad = ($urandom_range(99) < 70) ? 16'($urandom_range(255)) : 16'($urandom);
                issue(CMD_WRITE_MEM, ad, 16'($urandom), 1'b0, '0);
            end else if (k < 87) begin
                ad = loaded_addrs[$urandom_range(loaded_addrs.size() - 1)];
                issue(CMD_READ_MEM, ad, 16'($urandom), 1'b0, '0);
            end else begin
                issue(CMD_READ_REG, 16'($urandom), 16'($urandom), 1'b0, '0);
            end
            sent++;
        end
        calm = 1'b0;
        may_halt = 1'b1;
        while (!halt_q) advance_program();
        for (int i = 0; i < 4; i++) begin
            issue(CMD_EXECUTE, 16'($urandom), 16'($urandom), 1'b0, '0);
            issue(CMD_READ_REG, 16'(i + 12), 16'd0, 1'b0, '0);
        end
        @(posedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && pending_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    task automatic check_beat();
        t_result exp_r;
        t_result got;
        got.read_data = m_axis_tdata[31:0];
        got.pc = m_axis_tdata[47:32];
        got.halted = m_axis_tdata[48];
        got.count = m_axis_tdata[80:49];
        got.highest = m_axis_tdata[96:81];
        results_seen++;
        if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("beat %0d: unexpected result", results_seen);
            return;
        end
        exp_r = pending_q.pop_front();
        if (got.read_data != exp_r.read_data || got.pc != exp_r.pc
                || got.halted != exp_r.halted || got.count != exp_r.count
                || got.highest != exp_r.highest) begin
            mismatches++;
            if (mismatches <= 10)
                $display("beat %0d: want data %h pc %h halt %b count %h high %h, got %h %h %b %h %h",
                         results_seen, exp_r.read_data, exp_r.pc, exp_r.halted, exp_r.count,
                         exp_r.highest, got.read_data, got.pc, got.halted, got.count,
                         got.highest);
        end
    endtask

    initial begin
        int hold;
        bit pressed;
        hold = 0;
        pressed = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) check_beat();
            if (hold > 0) begin
                hold--;
                m_axis_tready <= 1'b0;
            end else if (!pressed && results_seen >= 300) begin
                pressed = 1'b1;
                hold = 300;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= calm || $urandom_range(99) >= 35;
            end
        end
    end

    initial begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end
endmodule
